// ===== rtl/thcr_pkg.sv =====
`default_nettype none
package thcr_pkg;

  localparam int CODE_W = 16;
  localparam int POS_W  = 5;
  localparam int TAPS_W = 4;
  localparam int TIME_W = 16;
  localparam int IDX_W  = 2;

  localparam logic [IDX_W-1:0] CFG_HOLD_TIMEOUT  = 2'd0;
  localparam logic [IDX_W-1:0] CFG_HAND_AXIS     = 2'd1;
  localparam logic [IDX_W-1:0] CFG_HAND_BOUNDARY = 2'd2;

  localparam logic [TIME_W-1:0] HOLD_TIMEOUT_RST  = 16'd1000;
  localparam logic [POS_W-1:0]  HAND_BOUNDARY_RST = 5'd4;
  // tick expires the deadline when (t - d) mod 2^16 is below this
  localparam logic [TIME_W-1:0] EXPIRE_WINDOW     = 16'd32767;

  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0] hold_timeout;
    logic              hand_axis;
    logic [POS_W-1:0]  hand_boundary;
  } cfg_t;

  typedef struct packed {
    logic              opcode;
    logic [CODE_W-1:0] code;
    logic              tap_hold;
    logic              key_event;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic              pressed;
    logic [TAPS_W-1:0] taps;
    logic [TIME_W-1:0] tstamp;
  } item_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic              pressed;
    logic [TIME_W-1:0] tstamp;
    logic [TAPS_W-1:0] taps;
    logic              intr;
    logic              last;
  } res_t;

  typedef struct packed {
    logic [1:0]     cnt;
    res_t [2:0]     ent;
  } res_set_t;

  typedef struct packed {
    logic              unsettled;
    logic [CODE_W-1:0] code;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic [TIME_W-1:0] tstamp;
    logic [TIME_W-1:0] deadline;
  } held_t;

  function automatic res_t mk_res(logic [CODE_W-1:0] code, logic [POS_W-1:0] row,
                                  logic [POS_W-1:0] col, logic pressed,
                                  logic [TIME_W-1:0] tstamp, logic [TAPS_W-1:0] taps,
                                  logic intr);
    res_t r;
    r.code    = code;
    r.row     = row;
    r.col     = col;
    r.pressed = pressed;
    r.tstamp  = tstamp;
    r.taps    = taps;
    r.intr    = intr;
    r.last    = 1'b0;
    return r;
  endfunction

  function automatic logic left_hand(cfg_t cfg, logic [POS_W-1:0] row,
                                     logic [POS_W-1:0] col);
    logic [POS_W-1:0] c;
    c = cfg.hand_axis ? col : row;
    return c < cfg.hand_boundary;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/thcr_in.sv =====
`default_nettype none
module thcr_in (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_valid,
  output logic                s_ready,
  input  wire thcr_pkg::item_t s_item,
  input  wire logic           take,
  output logic                vld,
  output thcr_pkg::item_t     item
);
  import thcr_pkg::*;

  assign s_ready = !vld || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (s_ready) begin
      vld <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      item <= s_item;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/thcr_core.sv =====
`default_nettype none
module thcr_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire thcr_pkg::cfg_t  cfg,
  input  wire thcr_pkg::item_t it,
  input  wire logic            load,
  output thcr_pkg::res_set_t   rs,
  output logic                 unsettled
);
  import thcr_pkg::*;

  held_t             st;
  held_t             st_next;
  logic [TIME_W-1:0] diff;
  logic              expired;
  logic              arm;

  assign unsettled = st.unsettled;
  assign diff      = it.tstamp - st.deadline;
  assign expired   = diff < EXPIRE_WINDOW;
  assign arm       = it.tap_hold && (it.taps == '0) && it.pressed && it.key_event
                     && (cfg.hold_timeout != '0);

  always_comb begin
    rs      = '0;
    st_next = st;
    if (it.opcode == OP_TICK) begin
      if (st.unsettled && expired) begin
        rs.ent[0] = mk_res(st.code, st.row, st.col, 1'b1, st.tstamp, 4'd0, 1'b0);
        rs.cnt    = 2'd1;
        st_next.unsettled = 1'b0;
        st_next.code      = '0;
      end
    end else if (!st.unsettled) begin
      if (arm) begin
        st_next.unsettled = 1'b1;
        st_next.code      = it.code;
        st_next.row       = it.row;
        st_next.col       = it.col;
        st_next.tstamp    = it.tstamp;
        st_next.deadline  = it.tstamp + cfg.hold_timeout;
      end else begin
        rs.ent[0] = mk_res(it.code, it.row, it.col, it.pressed, it.tstamp, it.taps, 1'b0);
        rs.cnt    = 2'd1;
      end
    end else if (it.code == st.code && !it.pressed) begin
      // own release: plain tap
      rs.ent[0] = mk_res(st.code, st.row, st.col, 1'b1, st.tstamp, 4'd1, 1'b0);
      rs.ent[1] = mk_res(st.code, it.row, it.col, 1'b0, it.tstamp, 4'd1, 1'b0);
      rs.cnt    = 2'd2;
      st_next.unsettled = 1'b0;
      st_next.code      = '0;
    end else if (it.pressed && it.code != st.code) begin
      if (left_hand(cfg, st.row, st.col) != left_hand(cfg, it.row, it.col)) begin
        rs.ent[0] = mk_res(st.code, st.row, st.col, 1'b1, st.tstamp, 4'd0, 1'b0);
        rs.ent[1] = mk_res(it.code, it.row, it.col, it.pressed, it.tstamp, it.taps, 1'b0);
        rs.cnt    = 2'd2;
      end else begin
        rs.ent[0] = mk_res(st.code, st.row, st.col, 1'b1, st.tstamp, 4'd1, 1'b1);
        rs.ent[1] = mk_res(st.code, st.row, st.col, 1'b0, st.tstamp, 4'd1, 1'b1);
        rs.ent[2] = mk_res(it.code, it.row, it.col, it.pressed, it.tstamp, it.taps, 1'b0);
        rs.cnt    = 2'd3;
      end
      st_next.unsettled = 1'b0;
      st_next.code      = '0;
    end else begin
      rs.ent[0] = mk_res(it.code, it.row, it.col, it.pressed, it.tstamp, it.taps, 1'b0);
      rs.cnt    = 2'd1;
    end
    for (int k = 0; k < 3; k++) begin
      rs.ent[k].last = (2'(k) == rs.cnt - 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (load) begin
      st <= st_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/thcr_drain.sv =====
`default_nettype none
module thcr_drain (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire thcr_pkg::res_set_t rs,
  input  wire logic               m_ready,
  output logic                    m_valid,
  output thcr_pkg::res_t          head,
  output logic                    free
);
  import thcr_pkg::*;

  res_t [2:0] ent;
  logic [1:0] n;
  logic       take;

  assign m_valid = (n != 2'd0);
  assign take    = m_valid && m_ready;
  assign free    = (n == 2'd0) || (n == 2'd1 && m_ready);
  assign head    = ent[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      n <= 2'd0;
    end else if (load) begin
      n <= rs.cnt;
    end else if (take) begin
      n <= n - 2'd1;
    end
  end

  // results leave from slot 0, the rest shift down on each transfer
  always_ff @(posedge clk) begin
    if (load) begin
      ent <= rs.ent;
    end else if (take) begin
      ent[0] <= ent[1];
      ent[1] <= ent[2];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tap_hold_chord_resolver_top.sv =====
`default_nettype none
// channel   dir  handshake            payload
// s_*       in   s_tvalid/s_tready    key event or tick (tdata, tuser)
// m_*       out  m_tvalid/m_tready    settled event (tdata, tuser, tlast)
// cfg_*     in   cfg_valid/cfg_ready  register index and write data
//
// an item is taken into the input register, resolved combinationally into up to
// three results, and those leave one per cycle from the output buffer while
// m_tready is high; items that each give one result then pass one per cycle,
// and a new item loads only once the buffer is empty or its last result leaves
// reset restores the register defaults and releases any held key
// a stall on m_* fills the buffer, then the input register, then drops s_tready
module tap_hold_chord_resolver_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // code[15:0] row[20:16] col[25:21] pressed[26] tap_count[30:27] time[46:31]
  input  wire logic [47:0] s_tdata,
  // opcode[0] tap_hold[1] key_event[2]
  input  wire logic [2:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // code[15:0] row[20:16] col[25:21] pressed[26] time[42:27] tap_count[46:43]
  output logic [47:0]      m_tdata,
  // interrupted[0]
  output logic [0:0]       m_tuser,
  output logic             m_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import thcr_pkg::*;

  cfg_t     cfg;
  item_t    s_item;
  item_t    item;
  logic     in_vld;
  logic     load;
  logic     drain_free;
  logic     unsettled;
  res_set_t rs;
  res_t     head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hold_timeout  <= HOLD_TIMEOUT_RST;
      cfg.hand_axis     <= 1'b0;
      cfg.hand_boundary <= HAND_BOUNDARY_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HOLD_TIMEOUT:  cfg.hold_timeout  <= cfg_data;
        CFG_HAND_AXIS:     cfg.hand_axis     <= cfg_data[0];
        CFG_HAND_BOUNDARY: cfg.hand_boundary <= cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    s_item.opcode    = s_tuser[0];
    s_item.tap_hold  = s_tuser[1];
    s_item.key_event = s_tuser[2];
    s_item.code      = s_tdata[15:0];
    s_item.row       = s_tdata[20:16];
    s_item.col       = s_tdata[25:21];
    s_item.pressed   = s_tdata[26];
    s_item.taps      = s_tdata[30:27];
    s_item.tstamp    = s_tdata[46:31];
  end

  assign load = in_vld && drain_free;

  thcr_in u_in (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_tvalid),
    .s_ready (s_tready),
    .s_item  (s_item),
    .take    (load),
    .vld     (in_vld),
    .item    (item)
  );

  thcr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .it        (item),
    .load      (load),
    .rs        (rs),
    .unsettled (unsettled)
  );

  thcr_drain u_drain (
    .clk     (clk),
    .rst     (rst),
    .load    (load),
    .rs      (rs),
    .m_ready (m_tready),
    .m_valid (m_tvalid),
    .head    (head),
    .free    (drain_free)
  );

  assign m_tdata = {1'b0, head.taps, head.tstamp, head.pressed, head.col, head.row, head.code};
  assign m_tuser = head.intr;
  assign m_tlast = head.last;

  // last result taken with nothing pending leaves the output empty
  a_last_empties: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast && !in_vld |=> !m_tvalid)
    else $error("output still valid after last transfer");

  // a non-last result is always followed by another
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    else $error("run ended without last");

  // two or three results only come from settling the held key
  a_multi_settles: assert property (@(posedge clk) disable iff (rst)
    load && (rs.cnt == 2'd2 || rs.cnt == 2'd3) |=> !unsettled)
    else $error("key still held after settle");

  // an item with no result adds nothing to an empty output
  a_silent_item: assert property (@(posedge clk) disable iff (rst)
    load && rs.cnt == 2'd0 |=> !m_tvalid)
    else $error("result from silent item");

endmodule
`default_nettype wire
